// ===== rtl/core/rbei_pkg.sv =====
`default_nettype none
package rbei_pkg;

   // default sizes
   localparam int unsigned BODIES_DEF   = 64;
   localparam int unsigned NORM_ITER_DEF = 3;

   // request codes
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_STEP  = 2'd2;

   // register indexes
   localparam logic [1:0] CFG_DT = 2'd0;
   localparam logic [1:0] CFG_GX = 2'd1;
   localparam logic [1:0] CFG_GY = 2'd2;
   localparam logic [1:0] CFG_GZ = 2'd3;

   // component codes
   localparam logic [3:0] COMP_POS_X = 4'd0;
   localparam logic [3:0] COMP_VEL_X = 4'd3;
   localparam logic [3:0] COMP_QUAT_W = 4'd6;
   localparam logic [3:0] COMP_RATE_X = 4'd10;
   localparam logic [3:0] COMP_RATE_Z = 4'd12;
   localparam logic [3:0] COMP_KIND  = 4'd13;
   localparam logic [3:0] COMP_QUAT_Z = 4'd9;

   localparam logic [1:0] KIND_DYNAMIC = 2'd3;

   localparam logic [16:0]        DT_RESET = 17'd1092;
   localparam logic signed [31:0] GY_RESET = -32'sd642253;

   // chord for the first inverse square root guess, Q2.30
   localparam logic [31:0] GUESS_A1 = 32'd1388314624;
   localparam logic [31:0] GUESS_B1 = 32'd314572800;
   localparam logic [31:0] GUESS_A2 = 32'd981467136;
   localparam logic [31:0] GUESS_B2 = 32'd111149056;
   localparam logic [31:0] THREE_Q30 = 32'hC000_0000;

   localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
   localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_KRD, S_KCHK, S_LRD, S_LLAT, S_MUL, S_ACC,
      S_NINIT, S_SHIFT, S_VEL, S_WB, S_NEXT, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_GD, PH_PH, PH_Q, PH_SQ, PH_GS, PH_NT, PH_FIN
   } phase_type;

   typedef enum logic [1:0] {WS_ZERO, WS_HOST, WS_BODY} wsrc_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  j;
      logic        mul;
      logic        acc;
      logic        load;
      logic        ninit;
      logic        shift;
      logic        vel;
      wsrc_type    wsrc;
      logic [3:0]  comp;
      logic [31:0] host_value;
   } cmd_type;

   typedef struct packed {
      logic s_zero;
      logic t_ready;
   } status_type;

   typedef struct packed {
      logic [1:0] hi;
      logic [1:0] qi;
      logic       neg;
      logic       first;
      logic       last;
      logic [1:0] row;
   } qterm_type;

   // terms of (0,h)*q, three per result component
   function automatic qterm_type qterm(input logic [3:0] j);
      qterm_type r;
      case (j)
         4'd0:    r = '{hi: 2'd0, qi: 2'd1, neg: 1'b1, first: 1'b1, last: 1'b0, row: 2'd0};
         4'd1:    r = '{hi: 2'd1, qi: 2'd2, neg: 1'b1, first: 1'b0, last: 1'b0, row: 2'd0};
         4'd2:    r = '{hi: 2'd2, qi: 2'd3, neg: 1'b1, first: 1'b0, last: 1'b1, row: 2'd0};
         4'd3:    r = '{hi: 2'd0, qi: 2'd0, neg: 1'b0, first: 1'b1, last: 1'b0, row: 2'd1};
         4'd4:    r = '{hi: 2'd1, qi: 2'd3, neg: 1'b0, first: 1'b0, last: 1'b0, row: 2'd1};
         4'd5:    r = '{hi: 2'd2, qi: 2'd2, neg: 1'b1, first: 1'b0, last: 1'b1, row: 2'd1};
         4'd6:    r = '{hi: 2'd1, qi: 2'd0, neg: 1'b0, first: 1'b1, last: 1'b0, row: 2'd2};
         4'd7:    r = '{hi: 2'd2, qi: 2'd1, neg: 1'b0, first: 1'b0, last: 1'b0, row: 2'd2};
         4'd8:    r = '{hi: 2'd0, qi: 2'd3, neg: 1'b1, first: 1'b0, last: 1'b1, row: 2'd2};
         4'd9:    r = '{hi: 2'd2, qi: 2'd0, neg: 1'b0, first: 1'b1, last: 1'b0, row: 2'd3};
         4'd10:   r = '{hi: 2'd0, qi: 2'd2, neg: 1'b0, first: 1'b0, last: 1'b0, row: 2'd3};
         4'd11:   r = '{hi: 2'd1, qi: 2'd1, neg: 1'b1, first: 1'b0, last: 1'b1, row: 2'd3};
         default: r = '{hi: 2'd0, qi: 2'd0, neg: 1'b0, first: 1'b1, last: 1'b0, row: 2'd0};
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
      logic signed [31:0] r;
      if (x > SAT_HI) r = 32'sh7FFF_FFFF;
      else if (x < SAT_LO) r = 32'sh8000_0000;
      else r = x[31:0];
      return r;
   endfunction

   // round half up, then arithmetic shift right by sh (1..32)
   function automatic logic signed [67:0] rnd_sh(input logic signed [67:0] x,
                                                input logic [5:0] sh);
      logic signed [67:0] r;
      r = x + (68'sd1 <<< (sh - 6'd1));
      return r >>> sh;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rbei_ram.sv =====
`default_nettype none
module rbei_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/rbei_dp.sv =====
`default_nettype none
module rbei_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rbei_pkg::cmd_type cmd,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_wdata,
   input  wire logic [31:0]      ram_rdata,
   output logic      [31:0]      ram_wdata,
   output rbei_pkg::status_type  status
);
   import rbei_pkg::*;

   logic [16:0]        dt_ff;
   logic signed [31:0] g_ff [3];
   logic signed [31:0] p_ff [3], p_in [3];
   logic signed [31:0] v_ff [3], v_in [3];
   logic signed [31:0] q_ff [4], q_in [4];
   logic signed [31:0] w_ff [3], w_in [3];
   logic signed [31:0] gd_ff [3], gd_in [3];
   logic signed [31:0] h_ff [3], h_in [3];
   logic signed [31:0] e_ff [4], e_in [4];
   logic signed [31:0] qo_ff [4], qo_in [4];
   logic signed [67:0] acc_ff, acc_in;
   logic [62:0]        s_ff, s_in;
   logic [62:0]        t_ff, t_in;
   logic signed [5:0]  k_ff, k_in;
   logic [31:0]        y_ff, y_in, y2_ff, y2_in, br_ff, br_in;
   logic signed [65:0] prod_ff;
   logic signed [32:0] mul_a, mul_b;
   logic [1:0]         jj, jm3, ci;
   logic [31:0]        m_val;
   qterm_type          qt;
   logic signed [65:0] qprod;
   logic signed [67:0] qsum, wide;
   logic [35:0]        pnt;

   assign jj    = cmd.j[1:0];
   assign jm3   = 2'(cmd.j - 4'd3);
   assign m_val = t_ff[61:30];
   assign qt    = qterm(cmd.j);
   assign wide  = 68'(prod_ff);

   assign status.s_zero  = (s_ff == '0);
   assign status.t_ready = (t_ff[62:60] != 3'd0);

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.phase)
         PH_GD: begin
            mul_a = 33'(g_ff[jj]);
            mul_b = $signed({16'd0, dt_ff});
         end
         PH_PH: begin
            mul_a = (cmd.j < 4'd3) ? 33'(v_ff[jj]) : 33'(w_ff[jm3]);
            mul_b = $signed({16'd0, dt_ff});
         end
         PH_Q: begin
            mul_a = 33'(h_ff[qt.hi]);
            mul_b = 33'(q_ff[qt.qi]);
         end
         PH_SQ: begin
            mul_a = 33'(e_ff[jj]);
            mul_b = 33'(e_ff[jj]);
         end
         PH_GS: begin
            mul_a = $signed({1'b0, t_ff[61] ? GUESS_B2 : GUESS_B1});
            mul_b = $signed({1'b0, m_val});
         end
         PH_NT: begin
            case (jj)
               2'd0: begin
                  mul_a = $signed({1'b0, y_ff});
                  mul_b = $signed({1'b0, y_ff});
               end
               2'd1: begin
                  mul_a = $signed({1'b0, m_val});
                  mul_b = $signed({1'b0, y2_ff});
               end
               default: begin
                  mul_a = $signed({1'b0, y_ff});
                  mul_b = $signed({1'b0, br_ff});
               end
            endcase
         end
         PH_FIN: begin
            mul_a = 33'(e_ff[jj]);
            mul_b = $signed({1'b0, y_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      p_in = p_ff; v_in = v_ff; q_in = q_ff; w_in = w_ff;
      gd_in = gd_ff; h_in = h_ff; e_in = e_ff; qo_in = qo_ff;
      acc_in = acc_ff; s_in = s_ff; t_in = t_ff; k_in = k_ff;
      y_in = y_ff; y2_in = y2_ff; br_in = br_ff;
      qprod = qt.neg ? -prod_ff : prod_ff;
      qsum  = (qt.first ? 68'sd0 : acc_ff) + 68'(qprod >>> 2);
      pnt   = prod_ff[65:30];
      ci    = 2'd0;

      if (cmd.load) begin
         if (cmd.comp < COMP_VEL_X) begin
            ci = cmd.comp[1:0];
            p_in[ci] = ram_rdata;
         end else if (cmd.comp < COMP_QUAT_W) begin
            ci = 2'(cmd.comp - COMP_VEL_X);
            v_in[ci] = ram_rdata;
         end else if (cmd.comp < COMP_RATE_X) begin
            ci = 2'(cmd.comp - COMP_QUAT_W);
            q_in[ci] = ram_rdata;
         end else if (cmd.comp <= COMP_RATE_Z) begin
            ci = 2'(cmd.comp - COMP_RATE_X);
            w_in[ci] = ram_rdata;
         end
      end

      if (cmd.acc) begin
         case (cmd.phase)
            PH_GD: gd_in[jj] = sat32(rnd_sh(wide, 6'd16));
            PH_PH: begin
               if (cmd.j < 4'd3) begin
                  p_in[jj] = sat32(68'(p_ff[jj]) + 68'(sat32(rnd_sh(wide, 6'd16))));
               end else begin
                  h_in[jm3] = sat32(rnd_sh(wide, 6'd17));
               end
            end
            PH_Q: begin
               acc_in = qsum;
               if (qt.last) begin
                  e_in[qt.row] = sat32(68'(q_ff[qt.row])
                                       + 68'(sat32(rnd_sh(qsum, 6'd14))));
               end
            end
            PH_SQ: s_in = ((jj == 2'd0) ? 63'd0 : s_ff) + 63'(prod_ff >>> 2);
            PH_GS: y_in = (t_ff[61] ? GUESS_A2 : GUESS_A1) - prod_ff[61:30];
            PH_NT: begin
               case (jj)
                  2'd0: y2_in = prod_ff[61:30];
                  2'd1: br_in = (pnt >= 36'(THREE_Q30)) ? 32'd0
                                : 32'(36'(THREE_Q30) - pnt);
                  default: y_in = prod_ff[62:31];
               endcase
            end
            PH_FIN: qo_in[jj] = sat32(rnd_sh(wide, 6'(6'sd31 - k_ff)));
            default: acc_in = acc_ff;
         endcase
      end

      // normalization scale: s as given, or by 4 down when s reaches 2^62
      if (cmd.ninit) begin
         if (s_ff[62]) begin
            t_in = s_ff >> 2;
            k_in = -6'sd1;
         end else begin
            t_in = s_ff;
            k_in = 6'sd0;
         end
         if (s_ff == '0) begin
            for (int i = 0; i < 4; i++) qo_in[i] = '0;
         end
      end
      if (cmd.shift && !status.t_ready) begin
         t_in = t_ff << 2;
         k_in = k_ff + 6'sd1;
      end
      if (cmd.vel) begin
         for (int i = 0; i < 3; i++) v_in[i] = sat32(68'(v_ff[i]) + 68'(gd_ff[i]));
      end
   end

   always_comb begin
      ram_wdata = '0;
      case (cmd.wsrc)
         WS_HOST: ram_wdata = (cmd.comp == COMP_KIND) ? {30'd0, cmd.host_value[1:0]}
                                                      : cmd.host_value;
         WS_BODY: begin
            if (cmd.comp < COMP_VEL_X) ram_wdata = p_ff[cmd.comp[1:0]];
            else if (cmd.comp < COMP_QUAT_W) ram_wdata = v_ff[2'(cmd.comp - COMP_VEL_X)];
            else if (cmd.comp <= COMP_QUAT_Z) ram_wdata = qo_ff[2'(cmd.comp - COMP_QUAT_W)];
         end
         default: ram_wdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff   <= DT_RESET;
         g_ff[0] <= '0;
         g_ff[1] <= GY_RESET;
         g_ff[2] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CFG_DT:  dt_ff   <= csr_wdata[16:0];
            CFG_GX:  g_ff[0] <= csr_wdata;
            CFG_GY:  g_ff[1] <= csr_wdata;
            CFG_GZ:  g_ff[2] <= csr_wdata;
            default: dt_ff   <= dt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= mul_a * mul_b;
      end
      p_ff <= p_in; v_ff <= v_in; q_ff <= q_in; w_ff <= w_in;
      gd_ff <= gd_in; h_ff <= h_in; e_ff <= e_in; qo_ff <= qo_in;
      acc_ff <= acc_in; s_ff <= s_in; t_ff <= t_in; k_ff <= k_in;
      y_ff <= y_in; y2_ff <= y2_in; br_ff <= br_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/rbei_ctrl.sv =====
`default_nettype none
module rbei_ctrl #(
   parameter int unsigned BODIES          = rbei_pkg::BODIES_DEF,
   parameter int unsigned NORM_ITERATIONS = rbei_pkg::NORM_ITER_DEF,
   parameter int unsigned AW              = $clog2(BODIES)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [47:0]           req_tdata,
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,
   output logic                       rsp_tuser,
   output rbei_pkg::cmd_type          cmd,
   input  wire rbei_pkg::status_type  status,
   output logic                       ram_we,
   output logic [AW+3:0]              ram_addr,
   input  wire logic [31:0]           ram_rdata
);
   import rbei_pkg::*;

   localparam int unsigned ITW = $clog2(NORM_ITERATIONS + 1);

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [3:0]  j_ff, j_in;
   logic [ITW-1:0] it_ff, it_in;
   logic [AW-1:0]  body_ff, body_in;
   logic [AW+3:0]  clr_ff, clr_in;
   logic        dyn_ff, dyn_in, rok_ff, rok_in;
   logic        rsp_valid_ff, rsp_valid_in, rsp_done_ff, rsp_done_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [5:0]  req_body;
   logic [3:0]  req_comp;
   logic        accept, body_ok, comp_ok, rsp_free;

   assign req_body  = req_tdata[5:0];
   assign req_comp  = req_tdata[9:6];
   assign body_ok   = (32'(req_body) < 32'(BODIES));
   assign comp_ok   = (req_comp <= COMP_KIND);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign accept    = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_done_ff;

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; j_in = j_ff; it_in = it_ff;
      body_in = body_ff; clr_in = clr_ff; dyn_in = dyn_ff; rok_in = rok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_done_in = rsp_done_ff; rsp_data_in = rsp_data_ff;
      cmd = '0;
      cmd.phase = phase_ff;
      cmd.j = j_ff;
      ram_we = 1'b0;
      ram_addr = {body_ff, j_ff};

      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = clr_ff;
            cmd.wsrc = WS_ZERO;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            ram_addr = {AW'(req_body), req_comp};
            cmd.comp = req_comp;
            cmd.host_value = req_tdata[41:10];
            cmd.wsrc = WS_HOST;
            if (accept) begin
               case (req_tuser)
                  REQ_WRITE: ram_we = body_ok && comp_ok;
                  REQ_READ: begin
                     rok_in = body_ok && comp_ok;
                     state_in = S_READ;
                  end
                  REQ_STEP: begin
                     phase_in = PH_GD;
                     j_in = '0;
                     state_in = S_MUL;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_done_in = 1'b0;
            rsp_data_in = rok_ff ? ram_rdata : 32'd0;
            state_in = S_IDLE;
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            state_in = S_MUL;
            j_in = j_ff + 4'd1;
            case (phase_ff)
               PH_GD: if (j_ff == 4'd2) begin
                  body_in = '0;
                  state_in = S_KRD;
               end
               PH_PH: if (j_ff == 4'd5) begin
                  phase_in = PH_Q;
                  j_in = '0;
               end
               PH_Q: if (j_ff == 4'd11) begin
                  phase_in = PH_SQ;
                  j_in = '0;
               end
               PH_SQ: if (j_ff == 4'd3) state_in = S_NINIT;
               PH_GS: begin
                  phase_in = PH_NT;
                  j_in = '0;
                  it_in = '0;
               end
               PH_NT: if (j_ff == 4'd2) begin
                  j_in = '0;
                  if (it_ff == ITW'(NORM_ITERATIONS - 1)) phase_in = PH_FIN;
                  else it_in = it_ff + 1'b1;
               end
               PH_FIN: if (j_ff == 4'd3) state_in = S_VEL;
               default: state_in = S_MUL;
            endcase
         end
         S_KRD: begin
            ram_addr = {body_ff, COMP_KIND};
            state_in = S_KCHK;
         end
         S_KCHK: begin
            // deleted and static bodies are left alone
            if (ram_rdata[1]) begin
               dyn_in = (ram_rdata[1:0] == KIND_DYNAMIC);
               j_in = '0;
               state_in = S_LRD;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_LRD: state_in = S_LLAT;
         S_LLAT: begin
            cmd.load = 1'b1;
            cmd.comp = j_ff;
            j_in = j_ff + 4'd1;
            state_in = S_LRD;
            if (j_ff == COMP_RATE_Z) begin
               phase_in = PH_PH;
               j_in = '0;
               state_in = S_MUL;
            end
         end
         S_NINIT: begin
            cmd.ninit = 1'b1;
            state_in = status.s_zero ? S_VEL : S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.t_ready) begin
               phase_in = PH_GS;
               j_in = '0;
               state_in = S_MUL;
            end
         end
         S_VEL: begin
            cmd.vel = dyn_ff;
            j_in = '0;
            state_in = S_WB;
         end
         S_WB: begin
            ram_we = 1'b1;
            cmd.wsrc = WS_BODY;
            cmd.comp = j_ff;
            j_in = j_ff + 4'd1;
            if (j_ff == COMP_QUAT_Z) state_in = S_NEXT;
         end
         S_NEXT: begin
            if (body_ff == AW'(BODIES - 1)) begin
               state_in = S_DONE;
            end else begin
               body_in = body_ff + 1'b1;
               state_in = S_KRD;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_done_in = 1'b1;
               rsp_data_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff <= phase_in; j_ff <= j_in; it_ff <= it_in; body_ff <= body_in;
      dyn_ff <= dyn_in; rok_ff <= rok_in;
      rsp_done_ff <= rsp_done_in; rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_shift_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> !status.s_zero)
      else $error("normalize shift entered with zero magnitude");
   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> $past(state_ff == S_MUL))
      else $error("accumulate without a multiply");
   a_we_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_IDLE || state_ff == S_WB))
      else $error("table write outside clear, host write or write-back");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/rigid_body_euler_integrator_unit.sv =====
`default_nettype none
// Rigid body table with an explicit Euler step in Q16.16 / Q2.30 fixed point.
// After reset a clearing pass zeroes the table; no request is taken until it
// ends. A write is done on acceptance; a read passes a read state and answers
// with the value. A step walks every body in index order through one shared
// 33x33 multiplier, a multiply and an accumulate state per product: gravity
// setup, then per moving or dynamic body a load, products, normalize shifts,
// refinements and write-back, then one result with the done flag. Body state
// lives in one single-port-read table of BODIES*16 words.
module rigid_body_euler_integrator_unit #(
   parameter int unsigned BODIES          = rbei_pkg::BODIES_DEF,
   parameter int unsigned NORM_ITERATIONS = rbei_pkg::NORM_ITER_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // body_index[5:0], component[9:6], write_value[41:10]
   input  wire logic [1:0]  req_tuser,  // req_type
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // read_value
   output logic             rsp_tuser,  // step_done
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import rbei_pkg::*;

   localparam int unsigned AW = $clog2(BODIES);

   cmd_type        cmd;
   status_type     status;
   logic           ram_we;
   logic [AW+3:0]  ram_addr;
   logic [31:0]    ram_wdata, ram_rdata;

   // sequencer: host transfers, body walk and micro steps
   rbei_ctrl #(
      .BODIES(BODIES), .NORM_ITERATIONS(NORM_ITERATIONS), .AW(AW)
   ) u_ctrl (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .cmd, .status, .ram_we, .ram_addr, .ram_rdata
   );

   // arithmetic: body registers, multiplier, normalize
   rbei_dp u_dp (
      .clock, .reset, .cmd,
      .csr_we, .csr_index, .csr_wdata,
      .ram_rdata, .ram_wdata, .status
   );

   // body table, address is {body, component}
   rbei_ram #(.WIDTH(32), .DEPTH(BODIES * 16)) u_table (
      .clock,
      .we(ram_we), .waddr(ram_addr), .wdata(ram_wdata),
      .raddr(ram_addr), .rdata_ff(ram_rdata)
   );
endmodule
`default_nettype wire
